/* rtl/rpa_pkg.sv */
// ----------------------------------------------------------------------------
// rpa_pkg - shared definitions for the ratiometric pressure averager
// Widths, register indexes, divider select codes and controller handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rpa_pkg;

  localparam int RPA_WINDOW  = 16;
  localparam int SAMPLE_W    = 12;
  localparam int RATIO_FRAC  = 16;
  localparam int RATIO_DVD_W = SAMPLE_W + RATIO_FRAC;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KPA_GAIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADC_REF     = 2'd2;

  localparam logic [11:0] ADC_REF_RST = 12'd3270;

  // 0.1450377377 in Q24
  localparam logic signed [22:0] PSI_PER_KPA_Q24 = 23'sd2433329;

  // divider operand select
  localparam logic [1:0] DIV_SEL_P = 2'd0;
  localparam logic [1:0] DIV_SEL_V = 2'd1;
  localparam logic [1:0] DIV_SEL_R = 2'd2;

  typedef struct packed {
    logic       load_in;
    logic       update;
    logic       div_start;
    logic [1:0] div_sel;
    logic       cap_p;
    logic       cap_v;
    logic       cap_zero;
    logic       cap_chk;
    logic       cap_r;
    logic       mul1;
    logic       mul2;
    logic       out_load;
  } rpa_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic ratio_ok;
    logic div_busy;
    logic out_full;
  } rpa_stat_t;

endpackage

/* rtl/rpa_if.sv */
// ----------------------------------------------------------------------------
// rpa_if - request channels of the ratiometric pressure averager
// Sample channel in, result channel out; valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rpa_in_if import rpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] pressure_raw;
  logic [SAMPLE_W-1:0] supply_raw;

  modport source (output valid, output pressure_raw, output supply_raw, input ready);
  modport sink   (input valid, input pressure_raw, input supply_raw, output ready);
endinterface

interface rpa_out_if import rpa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [15:0] kpa_q4;
  logic signed [15:0] psi_q4;
  logic        [15:0] supply_mv;
  logic               result_valid;

  modport source (output valid, output kpa_q4, output psi_q4, output supply_mv,
                  output result_valid, input ready);
  modport sink   (input valid, input kpa_q4, input psi_q4, input supply_mv,
                  input result_valid, output ready);
endinterface

/* rtl/rpa_div.sv */
// ----------------------------------------------------------------------------
// rpa_div - restoring bit-serial divider
// One quotient bit per cycle; dividend is left-aligned, step count is loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpa_div import rpa_pkg::*; #(
  parameter int DVD_W = RATIO_DVD_W,
  parameter int DSR_W = 17
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [DVD_W-1:0]           dividend,
  input  logic [DSR_W-1:0]           divisor,
  input  logic [$clog2(DVD_W+1)-1:0] steps,
  output logic                       busy,
  output logic [DVD_W-1:0]           quotient
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DSR_W-1:0] rem_r;
  logic [DVD_W-1:0] quo_r;
  logic [DSR_W-1:0] dsr_r;
  logic [STEP_W-1:0] left_r;
  logic             busy_r;

  logic [DSR_W:0]   shifted;
  logic [DSR_W:0]   trial;
  logic             ge;

  always_comb begin
    shifted = {rem_r, quo_r[DVD_W-1]};
    trial   = shifted - {1'b0, dsr_r};
    ge      = (shifted >= {1'b0, dsr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      left_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      left_r <= steps;
    end else if (busy_r) begin
      left_r <= left_r - STEP_W'(1);
      if (left_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? trial[DSR_W-1:0] : shifted[DSR_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

/* rtl/rpa_dp.sv */
// ----------------------------------------------------------------------------
// rpa_dp - datapath of the ratiometric pressure averager
// Sample rings, running sums, shared divider, scaling multipliers, result reg.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpa_dp import rpa_pkg::*; #(
  parameter int WINDOW = RPA_WINDOW
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [SAMPLE_W-1:0]   in_pressure_raw,
  input  logic [SAMPLE_W-1:0]   in_supply_raw,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic signed [15:0]    out_kpa_q4,
  output logic signed [15:0]    out_psi_q4,
  output logic [15:0]           out_supply_mv,
  output logic                  out_result_valid,
  input  rpa_cmd_t              cmd,
  output rpa_stat_t             stat
);

  localparam int SUM_W  = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int DSR_W  = SUM_W + 1;
  localparam int STEP_W = $clog2(RATIO_DVD_W + 1);
  localparam int MVP_W  = (SUM_W + 14 > 29) ? SUM_W + 14 : 29;
  localparam int DIFF_W = RATIO_DVD_W + 1;
  localparam int P1_W   = DIFF_W + CFG_DATA_W + 1;
  localparam int KPA_W  = P1_W - 20;
  localparam int P2_W   = KPA_W + 23;
  localparam int PSI_W  = P2_W - 24;

  function automatic logic signed [15:0] sat16s(input logic signed [31:0] x);
    if (x > 32'sd32767) begin
      return 16'sh7FFF;
    end else if (x < -32'sd32768) begin
      return -16'sh8000;
    end else begin
      return x[15:0];
    end
  endfunction

  // configuration registers
  logic [15:0]          zero_off_r;
  logic [CFG_DATA_W-1:0] kpa_gain_r;
  logic [11:0]          adc_ref_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_off_r <= '0;
      kpa_gain_r <= '0;
      adc_ref_r  <= ADC_REF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ZERO_OFFSET: zero_off_r <= cfg_data[15:0];
        CFG_KPA_GAIN:    kpa_gain_r <= cfg_data;
        CFG_ADC_REF:     adc_ref_r  <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // incoming sample
  logic [SAMPLE_W-1:0] p_new_r;
  logic [SAMPLE_W-1:0] v_new_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      p_new_r <= in_pressure_raw;
      v_new_r <= in_supply_raw;
    end
  end

  // sample rings: pressure in the upper half, supply in the lower half
  logic [2*SAMPLE_W-1:0] ring_mem [WINDOW];
  logic [2*SAMPLE_W-1:0] ring_rd_r;
  logic [WINDOW-1:0]     entry_vld_r;
  logic [IDX_W-1:0]      slot_r;

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      ring_mem[slot_r] <= {p_new_r, v_new_r};
    end
    ring_rd_r <= ring_mem[slot_r];
  end

  logic [SAMPLE_W-1:0] p_old;
  logic [SAMPLE_W-1:0] v_old;

  assign p_old = entry_vld_r[slot_r] ? ring_rd_r[2*SAMPLE_W-1:SAMPLE_W] : '0;
  assign v_old = entry_vld_r[slot_r] ? ring_rd_r[SAMPLE_W-1:0] : '0;

  logic [SUM_W-1:0] psum_r;
  logic [SUM_W-1:0] vsum_r;
  logic [CNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_vld_r <= '0;
      slot_r      <= '0;
      psum_r      <= '0;
      vsum_r      <= '0;
      cnt_r       <= '0;
    end else if (cmd.update) begin
      entry_vld_r[slot_r] <= 1'b1;
      slot_r <= (slot_r == IDX_W'(WINDOW - 1)) ? '0 : slot_r + IDX_W'(1);
      psum_r <= psum_r - SUM_W'(p_old) + SUM_W'(p_new_r);
      vsum_r <= vsum_r - SUM_W'(v_old) + SUM_W'(v_new_r);
      cnt_r  <= cnt_r - CNT_W'(p_old != '0) + CNT_W'(p_new_r != '0);
    end
  end

  // shared divider
  logic [RATIO_DVD_W-1:0] p_avg_shift;
  logic [RATIO_DVD_W-1:0] div_dvd;
  logic [DSR_W-1:0]       div_dsr;
  logic [STEP_W-1:0]      div_steps;
  logic                   div_busy;
  logic [RATIO_DVD_W-1:0] div_quo;

  logic [SAMPLE_W-1:0]    p_avg_r;
  logic [SUM_W-1:0]       v_avg_r;

  assign p_avg_shift = {p_avg_r, {RATIO_FRAC{1'b0}}};

  always_comb begin
    case (cmd.div_sel)
      DIV_SEL_P: begin
        div_dvd   = RATIO_DVD_W'(psum_r) << (RATIO_DVD_W - SUM_W);
        div_dsr   = DSR_W'(cnt_r);
        div_steps = STEP_W'(SUM_W);
      end
      DIV_SEL_V: begin
        div_dvd   = RATIO_DVD_W'(vsum_r) << (RATIO_DVD_W - SUM_W);
        div_dsr   = DSR_W'(cnt_r);
        div_steps = STEP_W'(SUM_W);
      end
      DIV_SEL_R: begin
        div_dvd   = p_avg_shift;
        div_dsr   = {v_avg_r, 1'b0};
        div_steps = STEP_W'(RATIO_DVD_W);
      end
      default: begin
        div_dvd   = '0;
        div_dsr   = '0;
        div_steps = STEP_W'(1);
      end
    endcase
  end

  rpa_div #(
    .DVD_W (RATIO_DVD_W),
    .DSR_W (DSR_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .steps    (div_steps),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // averages and ratio
  logic                   valid_r;
  logic [RATIO_DVD_W-1:0] ratio_r;
  logic                   ratio_ok;

  assign ratio_ok = (cnt_r != '0) && (v_avg_r != '0);

  always_ff @(posedge clk) begin
    if (cmd.cap_zero) begin
      p_avg_r <= '0;
      v_avg_r <= vsum_r;
    end
    if (cmd.cap_p) begin
      p_avg_r <= div_quo[SAMPLE_W-1:0];
    end
    if (cmd.cap_v) begin
      v_avg_r <= div_quo[SUM_W-1:0];
    end
    if (cmd.cap_chk) begin
      valid_r <= ratio_ok;
    end
    if (cmd.cap_r) begin
      ratio_r <= div_quo;
    end
  end

  // scaling: Q16 ratio times Q8 gain down to Q4, then psi factor; supply in mV
  logic signed [DIFF_W-1:0]       diff;
  logic signed [CFG_DATA_W:0]     gain_s;
  logic signed [P1_W-1:0]         prod1_r;
  logic signed [KPA_W-1:0]        kpa_full_r;
  logic signed [P2_W-1:0]         prod2_r;
  logic [SUM_W+1:0]               v3_r;
  logic [MVP_W-1:0]               mvp_r;

  assign diff   = $signed({1'b0, ratio_r}) - $signed({{(DIFF_W-16){1'b0}}, zero_off_r});
  assign gain_s = $signed({1'b0, kpa_gain_r});

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      prod1_r <= diff * gain_s;
      v3_r    <= (SUM_W+2)'({v_avg_r, 1'b0}) + (SUM_W+2)'(v_avg_r);
    end
    if (cmd.mul2) begin
      kpa_full_r <= $signed(prod1_r[P1_W-1:20]);
      prod2_r    <= $signed(prod1_r[P1_W-1:20]) * PSI_PER_KPA_Q24;
      mvp_r      <= MVP_W'(v3_r) * MVP_W'(adc_ref_r);
    end
  end

  logic signed [PSI_W-1:0] psi_full;
  logic [15:0]             mv_sat;

  assign psi_full = $signed(prod2_r[P2_W-1:24]);
  assign mv_sat   = ((mvp_r >> 28) != '0) ? 16'hFFFF : mvp_r[27:12];

  // result register
  logic               out_valid_r;
  logic signed [15:0] kpa_out_r;
  logic signed [15:0] psi_out_r;
  logic [15:0]        mv_out_r;
  logic               rv_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      kpa_out_r <= valid_r ? sat16s(32'(kpa_full_r)) : '0;
      psi_out_r <= valid_r ? sat16s(32'(psi_full)) : '0;
      mv_out_r  <= mv_sat;
      rv_out_r  <= valid_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kpa_q4       = kpa_out_r;
  assign out_psi_q4       = psi_out_r;
  assign out_supply_mv    = mv_out_r;
  assign out_result_valid = rv_out_r;

  assign stat.cnt_zero = (cnt_r == '0);
  assign stat.ratio_ok = ratio_ok;
  assign stat.div_busy = div_busy;
  assign stat.out_full = out_valid_r;

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(WINDOW))
    else $error("nonzero count exceeds window");

  a_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (psum_r == '0))
    else $error("pressure sum nonzero with no nonzero entries");

  a_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (psum_r == '0) |-> (cnt_r == '0))
    else $error("nonzero entries with zero pressure sum");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy)
    else $error("divider started while busy");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_valid_r)
    else $error("result register overwritten");
`endif

endmodule

/* rtl/rpa_ctrl.sv */
// ----------------------------------------------------------------------------
// rpa_ctrl - sequencer of the ratiometric pressure averager
// Steps one request through ring update, divisions, scaling and result load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpa_ctrl import rpa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  rpa_stat_t stat,
  output rpa_cmd_t  cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_UPDATE = 4'd1;
  localparam logic [3:0] ST_AVG    = 4'd2;
  localparam logic [3:0] ST_WAIT_P = 4'd3;
  localparam logic [3:0] ST_WAIT_V = 4'd4;
  localparam logic [3:0] ST_CHECK  = 4'd5;
  localparam logic [3:0] ST_WAIT_R = 4'd6;
  localparam logic [3:0] ST_MUL1   = 4'd7;
  localparam logic [3:0] ST_MUL2   = 4'd8;
  localparam logic [3:0] ST_FINISH = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_AVG;
      end
      ST_AVG: begin
        if (stat.cnt_zero) begin
          cmd.cap_zero = 1'b1;
          state_nxt    = ST_CHECK;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_SEL_P;
          state_nxt     = ST_WAIT_P;
        end
      end
      ST_WAIT_P: begin
        if (!stat.div_busy) begin
          cmd.cap_p     = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_SEL_V;
          state_nxt     = ST_WAIT_V;
        end
      end
      ST_WAIT_V: begin
        cmd.div_sel = DIV_SEL_V;
        if (!stat.div_busy) begin
          cmd.cap_v = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.cap_chk = 1'b1;
        if (stat.ratio_ok) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_SEL_R;
          state_nxt     = ST_WAIT_R;
        end else begin
          state_nxt = ST_MUL1;
        end
      end
      ST_WAIT_R: begin
        cmd.div_sel = DIV_SEL_R;
        if (!stat.div_busy) begin
          cmd.cap_r = 1'b1;
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!stat.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/ratiometric_pressure_averager.sv */
// ----------------------------------------------------------------------------
// ratiometric_pressure_averager - windowed ratiometric pressure conversion
// Conversion time is set by the bit-serial divider, which forms both averages
//   and the ratio; no division runs when no nonzero pressure is held.
// A new request is taken only once the previous one has loaded its result,
//   also while that result still waits. Synchronous reset empties the rings,
//   clears sums and count, and loads the configuration reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ratiometric_pressure_averager import rpa_pkg::*; #(
  parameter int WINDOW = RPA_WINDOW
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rpa_in_if.sink                in_ch,
  rpa_out_if.source             out_ch
);

  // Controller sequences; datapath holds rings, sums, divider and result reg.
  rpa_cmd_t  cmd;
  rpa_stat_t stat;

  rpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Each request: read old ring entry, update sums and count, divide for the
  // two averages (skipped when the count is zero), divide for the Q16 ratio
  // when valid, scale through two registered multiplies, load the result.
  rpa_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_pressure_raw  (in_ch.pressure_raw),
    .in_supply_raw    (in_ch.supply_raw),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_kpa_q4       (out_ch.kpa_q4),
    .out_psi_q4       (out_ch.psi_q4),
    .out_supply_mv    (out_ch.supply_mv),
    .out_result_valid (out_ch.result_valid),
    .cmd              (cmd),
    .stat             (stat)
  );

endmodule

/* tb/ratiometric_pressure_averager_tb.sv */
// ----------------------------------------------------------------------------
// ratiometric_pressure_averager_tb - self-checking bench for the averager
// Pushes pressure/supply sample requests through the windowed converter,
// predicts every reading from an in-bench model of the rings and the fixed
// point conversion, and compares each returned reading in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ratiometric_pressure_averager_tb;
  import rpa_pkg::*;

  // bench timing
  localparam int       DRAIN_CYCLES = 100;       // settle time after the queue drains
  localparam int       CYCLE_LIMIT  = 1_500_000;
  localparam int       MAX_GAP      = 40;
  // 0.1450377377 kPa to psi, Q24
  localparam longint   KPA_TO_PSI_Q24 = 2433329;

  // one converted reading, as it leaves the result channel
  typedef struct {
    logic signed [15:0] kpa_q4;
    logic signed [15:0] psi_q4;
    logic        [15:0] supply_mv;
    logic               result_valid;
  } reading_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rpa_in_if  in_ch ();
  rpa_out_if out_ch ();

  ratiometric_pressure_averager i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // --------------------------------------------------------------------------
  // Bench-side copy of the converter state. The rings start cleared, so the
  // running sums and the count of live (nonzero) pressure entries start at 0.
  // --------------------------------------------------------------------------
  logic [11:0] p_ring [RPA_WINDOW] = '{default: '0};
  logic [11:0] v_ring [RPA_WINDOW] = '{default: '0};
  int unsigned ring_slot  = 0;
  int unsigned p_total    = 0;
  int unsigned v_total    = 0;
  int unsigned live_count = 0;

  // calibration registers as last written (reset values)
  logic [15:0] cal_zero_q16 = '0;
  logic [19:0] cal_gain_q8  = '0;
  logic [11:0] cal_ref_mv   = ADC_REF_RST;

  reading_t    pending_readings [$];
  int          n_errors  = 0;
  int          idle_pct  = 0;   // sender: chance per cycle of holding off
  int          stall_pct = 0;   // receiver: chance per cycle of ready low

  // --------------------------------------------------------------------------
  // Clock, reset, watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: the slowest legal run is far below this.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic signed [15:0] clamp_s16(input longint x);
    if (x > 32767) return 16'sd32767;
    if (x < -32768) return -16'sd32768;
    return 16'(x);
  endfunction

  // --------------------------------------------------------------------------
  // Predictor: retire the oldest slot, store the new sample pair, recompute
  // both averages and the kPa / psi / mV reading.
  // --------------------------------------------------------------------------
  task automatic convert_sample(input logic [11:0] p_new, input logic [11:0] v_new,
                                output reading_t rd);
    int unsigned p_avg;
    int unsigned v_avg;
    longint      ratio_q16;
    longint      kpa_full;
    longint      psi_full;
    longint      mv;
    logic        ok;
    p_total = p_total - p_ring[ring_slot] + p_new;
    v_total = v_total - v_ring[ring_slot] + v_new;
    if (p_ring[ring_slot] != 0) live_count--;
    if (p_new != 0) live_count++;
    p_ring[ring_slot] = p_new;
    v_ring[ring_slot] = v_new;
    ring_slot = (ring_slot + 1) % RPA_WINDOW;

    // no live pressure: supply is reported as the plain window sum
    if (live_count > 0) begin
      p_avg = p_total / live_count;
      v_avg = v_total / live_count;
    end else begin
      p_avg = 0;
      v_avg = v_total;
    end
    ok = (live_count > 0) && (v_avg != 0);

    kpa_full = 0;
    psi_full = 0;
    if (ok) begin
      // ratio p/(2v) in Q16, then Q16 x Q8 -> Q4; >>> floors toward -inf
      ratio_q16 = (longint'(p_avg) << 16) / (longint'(v_avg) * 2);
      kpa_full  = ((ratio_q16 - longint'(cal_zero_q16)) * longint'(cal_gain_q8)) >>> 20;
      psi_full  = (kpa_full * KPA_TO_PSI_Q24) >>> 24;
    end
    mv = (longint'(v_avg) * 3 * longint'(cal_ref_mv)) >>> 12;
    if (mv > 65535) mv = 65535;

    rd.kpa_q4       = clamp_s16(kpa_full);
    rd.psi_q4       = clamp_s16(psi_full);
    rd.supply_mv    = 16'(mv);
    rd.result_valid = ok;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random ready, in-order compare at every accepted reading.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_readings.size() == 0) begin
        $error("reading returned with no request outstanding");
        n_errors++;
      end else begin
        want = pending_readings.pop_front();
        if (out_ch.kpa_q4 !== want.kpa_q4) begin
          $error("kpa_q4 mismatch: expected %0d, got %0d", want.kpa_q4, out_ch.kpa_q4);
          n_errors++;
        end
        if (out_ch.psi_q4 !== want.psi_q4) begin
          $error("psi_q4 mismatch: expected %0d, got %0d", want.psi_q4, out_ch.psi_q4);
          n_errors++;
        end
        if (out_ch.supply_mv !== want.supply_mv) begin
          $error("supply_mv mismatch: expected %0d, got %0d",
                 want.supply_mv, out_ch.supply_mv);
          n_errors++;
        end
        if (out_ch.result_valid !== want.result_valid) begin
          $error("result_valid mismatch: expected %0b, got %0b",
                 want.result_valid, out_ch.result_valid);
          n_errors++;
        end
      end
    end
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // --------------------------------------------------------------------------
  // Request side. valid stays high into the next request when no hold-off is
  // drawn, so it is only lowered when a gap is inserted (or at a drain).
  // --------------------------------------------------------------------------
  task automatic send_sample(input logic [11:0] p, input logic [11:0] v);
    reading_t want;
    int       gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid        <= 1'b0;
      in_ch.pressure_raw <= 12'($urandom);
      in_ch.supply_raw   <= 12'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.pressure_raw <= p;
    in_ch.supply_raw   <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    convert_sample(p, v, want);
    pending_readings.push_back(want);
  endtask

  // Let every outstanding reading come back, then let the block settle.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all three calibration registers; junk in the unused upper data
  // bits must be dropped by the block.
  task automatic set_registers(input logic [15:0] zero_q16, input logic [19:0] gain_q8,
                               input logic [11:0] adc_mv);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ZERO_OFFSET;
    cfg_data  <= {junk[19:16], zero_q16};
    @(posedge clk);
    cfg_index <= CFG_KPA_GAIN;
    cfg_data  <= gain_q8;
    @(posedge clk);
    cfg_index <= CFG_ADC_REF;
    cfg_data  <= {junk[19:12], adc_mv};
    @(posedge clk);
    cfg_we       <= 1'b0;
    cal_zero_q16 = zero_q16;
    cal_gain_q8  = gain_q8;
    cal_ref_mv   = adc_mv;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // Registers at reset (gain 0). First request has pressure but the supply
  // ring is still all zero: no ratio, flag low. Then a zero/zero pair and
  // full-scale and minimum pairs.
  task automatic test_power_up_window();
    send_sample(12'd2048, 12'd0);
    send_sample(12'd0,    12'd0);
    send_sample(12'hFFF,  12'hFFF);
    send_sample(12'd1,    12'd1);
    wait_drained();
  endtask

  // Flush the window with missing pressure: count drops to zero, supply is
  // the undivided sum, and with full-scale reference the mV value clips.
  task automatic test_empty_window();
    set_registers(16'd0, 20'hFFFFF, 12'hFFF);
    repeat (RPA_WINDOW) send_sample(12'd0, 12'hFFF);
    wait_drained();
  endtask

  // Gain at maximum with the offset at both ends: large negative kPa clips,
  // zero reference gives 0 mV.
  task automatic test_conversion_extremes();
    set_registers(16'hFFFF, 20'hFFFFF, 12'd0);
    send_sample(12'hFFF, 12'd1);
    send_sample(12'hAAA, 12'h555);
    wait_drained();
    set_registers(16'd0, 20'hFFFFF, 12'hFFF);
    send_sample(12'h555, 12'hAAA);
    send_sample(12'hFFF, 12'hFFF);
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Random traffic in scenes. Each scene biases the samples toward one part
  // of the behavior: ordinary windows, ratio near one half, starved supply (big
  // ratios, positive clipping), all-missing pressure, dead supply, sparse
  // pressure and raw extremes. Registers are redrawn between some scenes.
  // --------------------------------------------------------------------------
  task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                     input int n_items);
    int          sent;
    int          kind;
    int          len;
    int          tmp;
    logic [11:0] p;
    logic [11:0] v;
    logic [15:0] zero_q16;
    logic [19:0] gain_q8;
    logic [11:0] adc_mv;
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    sent      = 0;
    while (sent < n_items) begin
      if ($urandom_range(3) == 0) begin
        wait_drained();
        case ($urandom_range(3))
          0:       zero_q16 = 16'd0;
          1:       zero_q16 = 16'hFFFF;
          default: zero_q16 = 16'($urandom);
        endcase
        case ($urandom_range(4))
          0:       gain_q8 = 20'd0;
          1:       gain_q8 = 20'hFFFFF;
          2:       gain_q8 = 20'($urandom_range(1, 255));
          default: gain_q8 = 20'($urandom);
        endcase
        case ($urandom_range(4))
          0:       adc_mv = 12'd0;
          1:       adc_mv = 12'hFFF;
          2:       adc_mv = ADC_REF_RST;
          default: adc_mv = 12'($urandom);
        endcase
        set_registers(zero_q16, gain_q8, adc_mv);
      end
      kind = $urandom_range(9);
      len  = (kind == 6 || kind == 7) ? $urandom_range(16, 24) : $urandom_range(8, 40);
      for (int i = 0; i < len && sent < n_items; i++) begin
        p = 12'($urandom);
        v = 12'($urandom);
        case (kind)
          4: begin   // ratio near one half in Q16 terms
            tmp = int'(v) + $urandom_range(0, 128) - 64;
            p = (tmp < 0) ? 12'd0 : (tmp > 4095) ? 12'hFFF : 12'(tmp);
          end
          5: v = 12'($urandom_range(0, 63));
          6: p = 12'd0;
          7: begin
            v = 12'd0;
            if ($urandom_range(9) == 0) p = 12'd0;
          end
          8: if ($urandom_range(1) == 0) p = 12'd0;
          9: begin
            case ($urandom_range(3))
              0: p = 12'd0;
              1: p = 12'd1;
              2: p = 12'hFFF;
              default: ;
            endcase
            case ($urandom_range(3))
              0: v = 12'd0;
              1: v = 12'd1;
              2: v = 12'hFFF;
              default: ;
            endcase
          end
          default: if ($urandom_range(9) == 0) p = 12'd0;
        endcase
        send_sample(p, v);
        sent++;
      end
    end
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_ZERO_OFFSET;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.pressure_raw = '0;
    in_ch.supply_raw   = '0;
    out_ch.ready       = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_power_up_window();
    test_empty_window();
    test_conversion_extremes();
    test_random_traffic(0,  0,  440);   // full rate both sides
    test_random_traffic(72, 0,  440);   // sparse requests
    test_random_traffic(0,  72, 440);   // back-pressure
    test_random_traffic(25, 25, 430);   // both

    wait_drained();
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
